@@ design/randomized_hadamard_rotation_core_assert.svh @@
// assertion macros shared by the rotation core
`ifndef RANDOMIZED_HADAMARD_ROTATION_CORE_ASSERT_SVH
`define RANDOMIZED_HADAMARD_ROTATION_CORE_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define RHR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rhr assertion failed");

// next-cycle implication on clk_i, off during reset
`define RHR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rhr assertion failed");

`endif

@@ design/rhr_pkg.sv @@
// types and constants of the randomized hadamard rotation core
package rhr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RES_W       = 20;
  localparam int POS_W       = 6;
  localparam int CNT_W       = 7;
  localparam int ACC_W       = 23;
  localparam int PROD_W      = 41;
  localparam int SEED_W      = 64;
  localparam int KLOG_W      = 3;
  localparam int TABLE_N     = 64;
  localparam int OUT_TDATA_W = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C2     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C3     = 64'h94d049bb133111eb;
  localparam logic [63:0] SEED_XOR   = 64'h1234567890abcdef;

  localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;
  localparam int          RES_LIM       = 262144;
  localparam int          SCALE_BASE    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_DRAIN
  } rhr_state_e;

  typedef enum logic [2:0] {
    PH_ADD,
    PH_MUL0,
    PH_MUL1,
    PH_MUL2,
    PH_MUL3
  } rhr_phase_e;

  typedef struct packed {
    logic                busy;
    logic [TABLE_N-1:0]  first;
    logic [TABLE_N-1:0]  second;
  } sign_tab_t;

endpackage

@@ design/randomized_hadamard_rotation_core.sv @@
// randomized walsh-hadamard rotation core: ring of cells, sign generator, output pipe
//
//  channel  direction  handshake                 payload
//  s_axis   in         tvalid/tready             tdata sample, tuser opcode
//  m_axis   out        tvalid/tready             tdata result+position, tlast
//  cfg      in         cfg_we_i, no wait         cfg_idx_i, cfg_data_i
//
// a vector of n = 2^k items loads at one item per cycle into a ring of DIM cells while the sign generator is not busy
// the transform then runs k passes over the ring through its single butterfly
// results leave at one item per cycle through a two-register output pipe while m_axis_tready is high
// a new vector loads only after the last one has drained from the ring
// after reset and after each seed write the sign generator builds 128 signs, each in the steps PH_ADD and
// PH_MUL0 to PH_MUL3, and no item is accepted meanwhile; a stalled output holds the ring in place
module randomized_hadamard_rotation_core #(
  parameter int DIM = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rhr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [15:0] sample
  input  logic                                s_axis_tuser,   // [0] opcode
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rhr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [19:0] result, [25:20] position
  output logic                                m_axis_tlast,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rhr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rhr_pkg::SEED_W-1:0]          cfg_data_i
);
  import rhr_pkg::*;

  // largest usable k, floor(log2(DIM))
  localparam int KMAX = $clog2(DIM + 1) - 1;

  // control state
  rhr_state_e        state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [KLOG_W-1:0] pass_q, pass_d;
  logic              mode_q, mode_d;
  logic [KLOG_W-1:0] size_q;

  sign_tab_t         tab;

  // ring values
  logic signed [ACC_W-1:0] val [DIM];
  logic                    cell_ovr [DIM];
  logic signed [ACC_W-1:0] cell_ovr_val [DIM];

  logic [KLOG_W-1:0] k_act;
  logic [CNT_W-1:0]  n, nm1, len, lenm1;
  logic              s_acc;
  logic              shift_en;
  logic              bf_act;
  logic signed [ACC_W-1:0] a, b, tail, diff, samp_ext;
  logic              mode_eff, pre_pos;

  // output pipe
  logic                     s1_v_q;
  logic signed [PROD_W-1:0] s1_prod_q;
  logic [POS_W-1:0]         s1_pos_q;
  logic                     s1_last_q;
  logic                     s1_neg_q;
  logic                     o_v_q;
  logic [RES_W-1:0]         o_res_q;
  logic [POS_W-1:0]         o_pos_q;
  logic                     o_last_q;
  logic                     o_rdy, s1_rdy, s1_take;

  // sizes, clamped to what the ring holds
  assign k_act = (size_q > KLOG_W'(KMAX)) ? KLOG_W'(KMAX) : size_q;
  assign n     = CNT_W'(1) << k_act;
  assign nm1   = n - CNT_W'(1);
  assign len   = CNT_W'(1) << pass_q;
  assign lenm1 = len - CNT_W'(1);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= KLOG_W'(6);
    end else if (cfg_we_i && cfg_idx_i == CFG_SIZE) begin
      size_q <= cfg_data_i[KLOG_W-1:0];
    end
  end

  rhr_signgen u_signgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i && cfg_idx_i == CFG_SEED),
    .seed_i  (cfg_data_i),
    .tab_o   (tab)
  );

  assign s_axis_tready = (state_q == ST_LOAD) && !tab.busy;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign o_rdy   = !o_v_q || m_axis_tready;
  assign s1_rdy  = !s1_v_q || o_rdy;
  assign s1_take = (state_q == ST_DRAIN) && s1_rdy;

  // head element and its butterfly partner len cells ahead
  assign a = val[0];
  always_comb begin
    b = val[0];
    for (int p = 0; p < KMAX; p++) begin
      if (pass_q == KLOG_W'(p)) begin
        b = val[1 << p];
      end
    end
  end

  // first sign flip applied as items enter; mode comes from the first item
  assign mode_eff = (idx_q == '0) ? s_axis_tuser : mode_q;
  assign pre_pos  = mode_eff ? tab.second[idx_q[POS_W-1:0]] : tab.first[idx_q[POS_W-1:0]];
  assign samp_ext = ACC_W'($signed(s_axis_tdata[SAMPLE_W-1:0]));

  // pair (i, i+len) meets at the head when bit len of i is clear
  assign bf_act = (state_q == ST_PASS) && ((idx_q & len) == '0);
  assign diff   = a - b;

  always_comb begin
    unique case (state_q)
      ST_LOAD:  tail = pre_pos ? samp_ext : -samp_ext;
      ST_PASS:  tail = bf_act ? (a + b) : a;
      default:  tail = a;
    endcase
  end

  assign shift_en = s_acc || (state_q == ST_PASS) || s1_take;

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    // the tail of the ring takes the new value, cell len-1 takes the difference
    assign cell_ovr[c]     = (CNT_W'(c) == nm1) || (bf_act && CNT_W'(c) == lenm1);
    assign cell_ovr_val[c] = (CNT_W'(c) == nm1) ? tail : diff;

    rhr_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (shift_en),
      .ovr_i     (cell_ovr[c]),
      .nbr_i     (val[(c + 1) % DIM]),
      .ovr_val_i (cell_ovr_val[c]),
      .val_o     (val[c])
    );
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    mode_d  = mode_q;
    unique case (state_q)
      ST_LOAD: begin
        if (s_acc) begin
          if (idx_q == '0) begin
            mode_d = s_axis_tuser;
          end
          if (idx_q >= nm1) begin
            idx_d   = '0;
            pass_d  = '0;
            state_d = (k_act == '0) ? ST_DRAIN : ST_PASS;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      ST_PASS: begin
        if (idx_q >= nm1) begin
          idx_d  = '0;
          pass_d = pass_q + KLOG_W'(1);
          if (pass_q + KLOG_W'(1) >= k_act) begin
            state_d = ST_DRAIN;
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (s1_take) begin
          if (idx_q >= nm1) begin
            idx_d   = '0;
            state_d = ST_LOAD;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      idx_q   <= '0;
      pass_q  <= '0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      mode_q  <= mode_d;
    end
  end

  // scaling: odd k multiplies by 1/sqrt(2) in q16, even k keeps the q16 position
  logic signed [PROD_W-1:0] a_w, inv_w, prod_c;
  assign a_w    = PROD_W'(a);
  assign inv_w  = PROD_W'($signed({1'b0, INV_SQRT2_Q16}));
  assign prod_c = k_act[0] ? (a_w * inv_w) : (a_w <<< SCALE_BASE);

  // round half up, shift, second sign flip, saturate
  logic [4:0]               shamt;
  logic signed [PROD_W:0]   rnd, shv, rv, rs;
  assign shamt = 5'(SCALE_BASE) + 5'(k_act >> 1);
  assign rnd   = (PROD_W + 1)'(s1_prod_q) + ((PROD_W + 1)'(1) << (shamt - 5'd1));
  assign shv   = rnd >>> shamt;
  assign rv    = s1_neg_q ? -shv : shv;
  always_comb begin
    if (rv > (PROD_W + 1)'(RES_LIM)) begin
      rs = (PROD_W + 1)'(RES_LIM);
    end else if (rv < -(PROD_W + 1)'(RES_LIM)) begin
      rs = -(PROD_W + 1)'(RES_LIM);
    end else begin
      rs = rv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= s1_take;
      end
      if (o_rdy) begin
        o_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_prod_q <= prod_c;
      s1_pos_q  <= idx_q[POS_W-1:0];
      s1_last_q <= (idx_q == nm1);
      s1_neg_q  <= !(mode_q ? tab.first[idx_q[POS_W-1:0]] : tab.second[idx_q[POS_W-1:0]]);
    end
    if (o_rdy && s1_v_q) begin
      o_res_q  <= rs[RES_W-1:0];
      o_pos_q  <= s1_pos_q;
      o_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - RES_W - POS_W)'(0), o_pos_q, o_res_q};
  assign m_axis_tlast  = o_last_q;

  `include "randomized_hadamard_rotation_core_assert.svh"

  // a stalled first stage keeps its item
  `RHR_ASSERT_NXT(a_s1_hold, s1_v_q && !o_rdy, s1_v_q)
  // the ring does not move while the output side is full
  `RHR_ASSERT_NXT(a_drain_hold, state_q == ST_DRAIN && !s1_rdy, state_q == ST_DRAIN && $stable(idx_q))
  // no item enters while the sign tables are being rebuilt
  `RHR_ASSERT_IMP(a_busy_block, tab.busy, !s_acc)

endmodule

@@ design/rhr_cell.sv @@
// one storage cell of the shifting vector ring
module rhr_cell (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic                            ovr_i,
  input  logic signed [rhr_pkg::ACC_W-1:0] nbr_i,
  input  logic signed [rhr_pkg::ACC_W-1:0] ovr_val_i,
  output logic signed [rhr_pkg::ACC_W-1:0] val_o
);
  import rhr_pkg::*;

  logic signed [ACC_W-1:0] val_q;
  logic signed [ACC_W-1:0] val_d;

  // take the neighbor's value or a replacement from the butterfly
  assign val_d = ovr_i ? ovr_val_i : nbr_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

@@ design/rhr_signgen.sv @@
// splitmix64 sign table generator on one shared 32x32 multiplier
module rhr_signgen (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rhr_pkg::SEED_W-1:0]   seed_i,
  output rhr_pkg::sign_tab_t           tab_o
);
  import rhr_pkg::*;

  rhr_phase_e          ph_q;
  logic [SEED_W-1:0]   seed_q;
  logic [SEED_W-1:0]   st_q;
  logic [5:0]          idx_q;
  logic                tbl_q;
  logic                busy_q;
  logic [63:0]         p0_q;
  logic [31:0]         acc_q;
  logic [63:0]         y_q;
  logic [TABLE_N-1:0]  first_q;
  logic [TABLE_N-1:0]  second_q;

  logic [63:0] z;
  logic [63:0] yx;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul;
  logic        sbit;

  assign z  = st_q ^ (st_q >> 30);
  assign yx = y_q ^ (y_q >> 27);

  always_comb begin
    unique case (ph_q)
      PH_MUL0: begin op_a = z[31:0];  op_b = MIX_C2[31:0];  end
      PH_MUL1: begin op_a = z[63:32]; op_b = MIX_C2[31:0];  end
      PH_MUL2: begin op_a = z[31:0];  op_b = MIX_C2[63:32]; end
      PH_MUL3: begin op_a = yx[31:0]; op_b = MIX_C3[31:0];  end
      default: begin op_a = 32'h0;    op_b = 32'h0;         end
    endcase
  end

  assign mul  = op_a * op_b;
  // bit 0 of z ^ (z >> 31) needs only the low half of the last product
  assign sbit = mul[0] ^ mul[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_ADD;
      seed_q <= '0;
      st_q   <= '0;
      idx_q  <= '0;
      tbl_q  <= 1'b0;
      busy_q <= 1'b1;
    end else if (start_i) begin
      ph_q   <= PH_ADD;
      seed_q <= seed_i;
      st_q   <= seed_i;
      idx_q  <= '0;
      tbl_q  <= 1'b0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      unique case (ph_q)
        PH_ADD: begin
          st_q <= st_q + MIX_GOLDEN;
          ph_q <= PH_MUL0;
        end
        PH_MUL0: ph_q <= PH_MUL1;
        PH_MUL1: ph_q <= PH_MUL2;
        PH_MUL2: ph_q <= PH_MUL3;
        PH_MUL3: begin
          ph_q <= PH_ADD;
          if (idx_q == 6'(TABLE_N - 1)) begin
            idx_q <= '0;
            if (!tbl_q) begin
              tbl_q <= 1'b1;
              st_q  <= seed_q ^ SEED_XOR;
            end else begin
              busy_q <= 1'b0;
            end
          end else begin
            idx_q <= idx_q + 6'd1;
          end
        end
        default: ph_q <= PH_ADD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      case (ph_q)
        PH_MUL0: p0_q  <= mul;
        PH_MUL1: acc_q <= mul[31:0];
        PH_MUL2: y_q   <= p0_q + {acc_q + mul[31:0], 32'h0};
        PH_MUL3: begin
          if (tbl_q) begin
            second_q[idx_q] <= sbit;
          end else begin
            first_q[idx_q] <= sbit;
          end
        end
        default: ;
      endcase
    end
  end

  assign tab_o.busy   = busy_q;
  assign tab_o.first  = first_q;
  assign tab_o.second = second_q;

endmodule
